// ===== rtl/alb_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and the fifth-root threshold table for the
// ambient-light backlight core. No dependencies.
package alb_pkg;

    localparam int SAMPLE_BITS_DEF = 10;

    // Threshold width: three bits above the default sample width, so a saturated
    // entry is always at or above any sample of that width.
    localparam int THR_W     = 13;
    localparam int THR_MAX   = (1 << THR_W) - 1;
    localparam int ROOT_BITS = 8;
    localparam int R_MIN     = 11;
    localparam int ROOT_SCALE = 100000;

    localparam int STEP_W = 4;
    localparam int CNT_W  = 5;
    localparam int NUM_W  = 16;
    localparam int B_W    = 13;
    localparam int QUO_W  = 22;
    localparam int DIV1_BITS = 14;
    localparam int DIV_SCALE = 25;

    // Divide by 25 as a multiply by ceil(2^26 / 25) and a shift; exact for
    // every scale product below 2^21.
    localparam int RECIP_SHIFT = 26;
    localparam int RECIP_W     = 22;
    localparam int RECIP_MUL   = ((1 << RECIP_SHIFT) + DIV_SCALE - 1) / DIV_SCALE;

    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 8;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_DIM_BL    = 3'd0,
        CFG_BRIGHT_BL = 3'd1,
        CFG_DIM_PH    = 3'd2,
        CFG_BRIGHT_PH = 3'd3,
        CFG_CONTRAST  = 3'd4,
        CFG_PWM_FLOOR = 3'd5,
        CFG_PWM_CEIL  = 3'd6
    } t_cfg_idx;

    typedef struct packed {
        logic [4:0] dim_bl;
        logic [4:0] bright_bl;
        logic [7:0] dim_ph;
        logic [7:0] bright_ph;
        logic [4:0] contrast;
        logic [7:0] pwm_floor;
        logic [7:0] pwm_ceil;
    } t_cfg;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_LOAD,
        OP_ROOT,
        OP_RFIX,
        OP_MUL_T,
        OP_MUL_N,
        OP_DIV1_INIT,
        OP_DIV_STEP,
        OP_TAKE_B,
        OP_SLEEP,
        OP_MUL_D,
        OP_SCALE,
        OP_FINISH
    } t_op;

    typedef enum logic [2:0] {
        COND_NEXT,
        COND_ALWAYS,
        COND_IDLE,
        COND_CNT_NZ,
        COND_NODIV
    } t_cond;

    // Program steps
    localparam logic [STEP_W-1:0] STEP_IDLE   = 4'd0;
    localparam logic [STEP_W-1:0] STEP_ROOT   = 4'd1;
    localparam logic [STEP_W-1:0] STEP_RFIX   = 4'd2;
    localparam logic [STEP_W-1:0] STEP_MUL_T  = 4'd3;
    localparam logic [STEP_W-1:0] STEP_MUL_N  = 4'd4;
    localparam logic [STEP_W-1:0] STEP_D1INIT = 4'd5;
    localparam logic [STEP_W-1:0] STEP_DIV1   = 4'd6;
    localparam logic [STEP_W-1:0] STEP_TAKE_B = 4'd7;
    localparam logic [STEP_W-1:0] STEP_SLEEP  = 4'd8;
    localparam logic [STEP_W-1:0] STEP_MUL_D  = 4'd9;
    localparam logic [STEP_W-1:0] STEP_SCALE  = 4'd10;
    localparam logic [STEP_W-1:0] STEP_FINISH = 4'd11;

    typedef struct packed {
        t_op                op;
        t_cond              cond;
        logic [STEP_W-1:0]  target;
    } t_ctrl;

    typedef struct packed {
        logic cnt_nz;
        logic no_div;
    } t_stat;

    // Entry r: largest sample s with s * 100000 <= r^5, saturated.
    typedef logic [(1<<ROOT_BITS)-1:0][THR_W-1:0] t_thr_tab;

    function automatic t_thr_tab f_build_thr();
        t_thr_tab    tab;
        longint      p;
        longint      t;
        for (int i = 0; i < (1 << ROOT_BITS); i++) begin
            p = longint'(i) * i * i * i * i;
            t = p / ROOT_SCALE;
            if (t > THR_MAX) begin
                t = THR_MAX;
            end
            tab[i] = THR_W'(t);
        end
        return tab;
    endfunction

    localparam t_thr_tab THR_TAB = f_build_thr();

endpackage

// ===== rtl/alb_cfg_regs.sv =====
`timescale 1ns / 1ps
// Configuration register file for the backlight core.
// Depends on alb_pkg.
module alb_cfg_regs (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_we,
    input  logic [alb_pkg::CFG_ADDR_W-1:0]    i_addr,
    input  logic [alb_pkg::CFG_DATA_W-1:0]    i_data,
    output alb_pkg::t_cfg                     o_cfg
);
    import alb_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_we) begin
            case (t_cfg_idx'(i_addr))
                CFG_DIM_BL:    n_cfg.dim_bl    = i_data[4:0];
                CFG_BRIGHT_BL: n_cfg.bright_bl = i_data[4:0];
                CFG_DIM_PH:    n_cfg.dim_ph    = i_data;
                CFG_BRIGHT_PH: n_cfg.bright_ph = i_data;
                CFG_CONTRAST:  n_cfg.contrast  = i_data[4:0];
                CFG_PWM_FLOOR: n_cfg.pwm_floor = i_data;
                CFG_PWM_CEIL:  n_cfg.pwm_ceil  = i_data;
                default:       n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.dim_bl    <= 5'd5;
            r_cfg.bright_bl <= 5'd20;
            r_cfg.dim_ph    <= 8'd40;
            r_cfg.bright_ph <= 8'd20;
            r_cfg.contrast  <= 5'd10;
            r_cfg.pwm_floor <= 8'd200;
            r_cfg.pwm_ceil  <= 8'd255;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== rtl/alb_ucode_rom.sv =====
`timescale 1ns / 1ps
// Control store: one control word per program step.
// Depends on alb_pkg.
module alb_ucode_rom (
    input  logic [alb_pkg::STEP_W-1:0] i_pc,
    output alb_pkg::t_ctrl             o_ctrl
);
    import alb_pkg::*;

    always_comb begin
        case (i_pc)
            STEP_IDLE:   o_ctrl = '{OP_LOAD,      COND_IDLE,   STEP_IDLE};
            STEP_ROOT:   o_ctrl = '{OP_ROOT,      COND_CNT_NZ, STEP_ROOT};
            STEP_RFIX:   o_ctrl = '{OP_RFIX,      COND_NEXT,   STEP_IDLE};
            STEP_MUL_T:  o_ctrl = '{OP_MUL_T,     COND_NEXT,   STEP_IDLE};
            STEP_MUL_N:  o_ctrl = '{OP_MUL_N,     COND_NEXT,   STEP_IDLE};
            STEP_D1INIT: o_ctrl = '{OP_DIV1_INIT, COND_NODIV,  STEP_SLEEP};
            STEP_DIV1:   o_ctrl = '{OP_DIV_STEP,  COND_CNT_NZ, STEP_DIV1};
            STEP_TAKE_B: o_ctrl = '{OP_TAKE_B,    COND_NEXT,   STEP_IDLE};
            STEP_SLEEP:  o_ctrl = '{OP_SLEEP,     COND_NEXT,   STEP_IDLE};
            STEP_MUL_D:  o_ctrl = '{OP_MUL_D,     COND_NEXT,   STEP_IDLE};
            STEP_SCALE:  o_ctrl = '{OP_SCALE,     COND_NEXT,   STEP_IDLE};
            STEP_FINISH: o_ctrl = '{OP_FINISH,    COND_ALWAYS, STEP_IDLE};
            default:     o_ctrl = '{OP_NOP,       COND_ALWAYS, STEP_IDLE};
        endcase
    end

endmodule

// ===== rtl/alb_datapath.sv =====
`timescale 1ns / 1ps
// Datapath: root search, restoring divider for the span, reciprocal scale,
// multiplies, output regs. Depends on alb_pkg.
module alb_datapath #(
    parameter int SAMPLE_BITS = alb_pkg::SAMPLE_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  alb_pkg::t_op           i_op,
    input  alb_pkg::t_cfg          i_cfg,
    input  logic [SAMPLE_BITS-1:0] i_light_sample,
    input  logic                   i_awake,
    output alb_pkg::t_stat         o_stat,
    output logic                   o_result_strobe,
    output logic [7:0]             o_backlight_pwm,
    output logic [6:0]             o_contrast_duty
);
    import alb_pkg::*;

    logic [SAMPLE_BITS-1:0]  r_smp;
    logic                    r_awake;
    logic [ROOT_BITS-1:0]    r_acc;
    logic [CNT_W-1:0]        r_cnt;
    logic signed [NUM_W-1:0] r_num;
    logic [B_W-1:0]          r_b;
    logic [QUO_W-1:0]        r_quo;
    logic [7:0]              r_rem;
    logic [7:0]              r_dvs;
    logic                    r_strobe;
    logic [7:0]              r_bl;
    logic [6:0]              r_ct;

    logic [7:0]              w_span;
    logic signed [5:0]       w_range;
    logic [ROOT_BITS-1:0]    w_cand;
    logic                    w_below;
    logic [ROOT_BITS-1:0]    w_r_inc;
    logic [ROOT_BITS-1:0]    w_r_fix;
    logic signed [8:0]       w_dpr;
    logic signed [14:0]      w_t;
    logic [12:0]             w_dspan;
    logic                    w_nodiv;
    logic [8:0]              w_trial;
    logic                    w_sub;
    logic [7:0]              w_pwm_d;
    logic [QUO_W-1:0]        w_prod;
    logic [QUO_W+RECIP_W-1:0] w_scl;
    logic [13:0]             w_slp;
    logic [17:0]             w_v;
    logic [7:0]              w_bl;

    assign w_span  = (i_cfg.dim_ph > i_cfg.bright_ph) ? (i_cfg.dim_ph - i_cfg.bright_ph)
                                                      : (i_cfg.bright_ph - i_cfg.dim_ph);
    assign w_range = $signed({1'b0, i_cfg.bright_bl}) - $signed({1'b0, i_cfg.dim_bl});

    // one bit of the root per step, MSB first
    assign w_cand  = r_acc | (ROOT_BITS'(1) << r_cnt[$clog2(ROOT_BITS)-1:0]);
    assign w_below = THR_TAB[w_cand] < {{(THR_W-SAMPLE_BITS){1'b0}}, r_smp};
    assign w_r_inc = r_acc + ROOT_BITS'(1);
    assign w_r_fix = (w_r_inc < ROOT_BITS'(R_MIN)) ? ROOT_BITS'(R_MIN) : w_r_inc;

    assign w_dpr   = $signed({1'b0, i_cfg.dim_ph}) - $signed({1'b0, r_acc});
    assign w_t     = $signed({{9{w_range[5]}}, w_range}) * $signed({{6{w_dpr[8]}}, w_dpr});
    assign w_dspan = {8'd0, i_cfg.dim_bl} * {5'd0, w_span};
    assign w_nodiv = (w_span <= 8'd1) || r_num[NUM_W-1];

    assign w_trial = {r_rem, r_quo[QUO_W-1]};
    assign w_sub   = w_trial >= {1'b0, r_dvs};

    assign w_pwm_d = i_cfg.pwm_ceil - i_cfg.pwm_floor;
    assign w_prod  = {{(QUO_W-B_W){1'b0}}, r_b} * {{(QUO_W-8){1'b0}}, w_pwm_d};
    // scale product / 25 by reciprocal multiply
    assign w_scl   = {{RECIP_W{1'b0}}, r_quo} * {{QUO_W{1'b0}}, RECIP_W'(RECIP_MUL)};
    assign w_slp   = {1'b0, r_b} + {9'd0, i_cfg.dim_bl};

    // quotient of the scale division stays below 2^17
    assign w_v = {1'b0, r_quo[16:0]} + {10'd0, i_cfg.pwm_floor};
    always_comb begin
        if (i_cfg.pwm_ceil < i_cfg.pwm_floor) begin
            w_bl = i_cfg.pwm_floor;
        end else if (w_v > {10'd0, i_cfg.pwm_ceil}) begin
            w_bl = i_cfg.pwm_ceil;
        end else begin
            w_bl = w_v[7:0];
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_op)
            OP_LOAD: begin
                r_smp   <= i_light_sample;
                r_awake <= i_awake;
                r_acc   <= '0;
                r_cnt   <= CNT_W'(ROOT_BITS - 1);
            end
            OP_ROOT: begin
                if (w_below) begin
                    r_acc <= w_cand;
                end
                r_cnt <= r_cnt - CNT_W'(1);
            end
            OP_RFIX: begin
                r_acc <= w_r_fix;
            end
            OP_MUL_T: begin
                r_num <= NUM_W'(w_t);
            end
            OP_MUL_N: begin
                r_num <= r_num + $signed({3'd0, w_dspan});
            end
            OP_DIV1_INIT: begin
                if (w_span <= 8'd1) begin
                    r_b <= {8'd0, i_cfg.bright_bl};
                end else if (r_num[NUM_W-1]) begin
                    r_b <= '0;
                end
                r_quo <= {r_num[DIV1_BITS-1:0], {(QUO_W-DIV1_BITS){1'b0}}};
                r_rem <= '0;
                r_dvs <= w_span;
                r_cnt <= CNT_W'(DIV1_BITS - 1);
            end
            OP_DIV_STEP: begin
                r_rem <= w_sub ? 8'(w_trial - {1'b0, r_dvs}) : w_trial[7:0];
                r_quo <= {r_quo[QUO_W-2:0], w_sub};
                r_cnt <= r_cnt - CNT_W'(1);
            end
            OP_TAKE_B: begin
                r_b <= r_quo[B_W-1:0];
            end
            OP_SLEEP: begin
                if (!r_awake) begin
                    r_b <= w_slp[B_W:1];
                end
            end
            OP_MUL_D: begin
                r_quo <= w_prod;
            end
            OP_SCALE: begin
                r_quo <= QUO_W'(w_scl[QUO_W+RECIP_W-1:RECIP_SHIFT]);
            end
            OP_FINISH: begin
                r_bl <= w_bl;
                r_ct <= {2'd0, i_cfg.contrast} + {1'b0, i_cfg.contrast, 1'b0};
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= (i_op == OP_FINISH);
        end
    end

    assign o_stat.cnt_nz    = (r_cnt != '0);
    assign o_stat.no_div    = w_nodiv;
    assign o_result_strobe  = r_strobe;
    assign o_backlight_pwm  = r_bl;
    assign o_contrast_duty  = r_ct;

endmodule

// ===== rtl/ambient_light_backlight_pwm_core.sv =====
`timescale 1ns / 1ps
// A sample runs from the start beat through 8 root steps, 14 divider steps and
// 9 single steps to the strobe cycle when the span is divided; the divider steps
// and TAKE_B are skipped when the span is 1 or less or the numerator is negative.
// No new sample is taken while busy; a new start is taken in the
// strobe cycle. The receiver cannot stall; each result shows 1 cycle. Reset:
// synchronous, sequencer idle, strobe low, config to defaults. Uses alb_*.
module ambient_light_backlight_pwm_core #(
    parameter int SAMPLE_BITS = alb_pkg::SAMPLE_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // sample command
    input  logic                               start,
    output logic                               busy,
    input  logic [SAMPLE_BITS-1:0]             i_light_sample,
    input  logic                               i_awake,
    // result
    output logic                               o_result_strobe,
    output logic [7:0]                         o_backlight_pwm,
    output logic [6:0]                         o_contrast_duty,
    // register writes
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [alb_pkg::CFG_ADDR_W-1:0]     i_cfg_addr,
    input  logic [alb_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import alb_pkg::*;

    // Program counter of the microcode sequencer. Step 0 waits for start and
    // keeps loading the sample; every other step is one datapath operation.
    logic [STEP_W-1:0] r_pc;
    logic [STEP_W-1:0] n_pc;
    t_ctrl             w_ctrl;
    t_stat             w_stat;
    t_cfg              w_cfg;
    logic              w_jump;

    // Config writes must be issued only while idle (the block does not enforce it); the port never pushes back.
    assign o_cfg_ready = 1'b1;

    alb_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (i_cfg_valid & o_cfg_ready),
        .i_addr  (i_cfg_addr),
        .i_data  (i_cfg_data),
        .o_cfg   (w_cfg)
    );

    alb_ucode_rom u_rom (
        .i_pc   (r_pc),
        .o_ctrl (w_ctrl)
    );

    // Branch condition of the current control word
    always_comb begin
        case (w_ctrl.cond)
            COND_NEXT:   w_jump = 1'b0;
            COND_ALWAYS: w_jump = 1'b1;
            COND_IDLE:   w_jump = !start;
            COND_CNT_NZ: w_jump = w_stat.cnt_nz;
            COND_NODIV:  w_jump = w_stat.no_div;
            default:     w_jump = 1'b1;
        endcase
    end

    assign n_pc = w_jump ? w_ctrl.target : (r_pc + STEP_W'(1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= STEP_IDLE;
        end else begin
            r_pc <= n_pc;
        end
    end

    assign busy = (r_pc != STEP_IDLE);

    alb_datapath #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_op            (w_ctrl.op),
        .i_cfg           (w_cfg),
        .i_light_sample  (i_light_sample),
        .i_awake         (i_awake),
        .o_stat          (w_stat),
        .o_result_strobe (o_result_strobe),
        .o_backlight_pwm (o_backlight_pwm),
        .o_contrast_duty (o_contrast_duty)
    );

endmodule

// ===== rtl/alb_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks for the backlight core, bound onto the top level.
// Depends on ambient_light_backlight_pwm_core.
module alb_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       start,
    input logic       busy,
    input logic       o_result_strobe,
    input logic [6:0] o_contrast_duty
);

    // a taken command occupies the block
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after start beat");

    // result comes out as the block frees up
    a_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_strobe |-> (!busy && $past(busy)))
        else $error("result strobe outside end of work");

    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_strobe |=> !o_result_strobe)
        else $error("result strobe held for two cycles");

    a_contrast_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_strobe |-> (o_contrast_duty <= 7'd93))
        else $error("contrast value above 3 x 31");

endmodule

bind ambient_light_backlight_pwm_core alb_checker u_alb_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .start           (start),
    .busy            (busy),
    .o_result_strobe (o_result_strobe),
    .o_contrast_duty (o_contrast_duty)
);
